// ----- rtl/fxalu_pkg.sv -----
// Shared types and constants for the fixed-point ALU.
package fxalu_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS_DEF = 8;

	typedef enum logic [3:0] {
		FN_ADD = 4'd0,
		FN_SUB = 4'd1,
		FN_MUL = 4'd2,
		FN_DIV = 4'd3,
		FN_INC = 4'd4,
		FN_DEC = 4'd5,
		FN_MIN = 4'd6,
		FN_MAX = 4'd7,
		FN_FROM_INT = 4'd8,
		FN_TO_INT = 4'd9
	} fn_t;

	// Per-word side data that travels beside the divider.
	typedef struct packed {
		logic [3:0] func;
		logic [WORD_BITS-1:0] simple;
		logic lt;
		logic eq;
		logic neg;
		logic dz;
		logic [2*WORD_BITS-1:0] prod;
	} meta_t;

endpackage

// ----- rtl/fixed_point_alu.sv -----
// Fixed-point ALU top level: pipelined add/sub/mul/div/min/max/convert.
//
// Usage:
//   Input channel src_valid/src_stall carries func, operand_a, operand_b.
//   A word is taken at a clock edge with src_valid high and src_stall low.
//   Output channel dst_valid/dst_stall carries result and the four flags
//   (less_than, equal_to, greater_than, divide_by_zero), one output word
//   per input word, in order.
// Pipeline: a capture stage, the divider stages and a registered output
//   stage (Q24.8 by default). The depth is set by the restoring divider,
//   which resolves one quotient bit per stage over WORD_BITS + FRAC_BITS
//   stages. Every operation runs the same path so words never reorder.
// Throughput: one word per cycle while the receiver does not stall.
// Multiply: one 32x32 product, registered, then carried alongside the
//   divider stages.
// Stall: the whole pipeline freezes when the output holds a word and
//   dst_stall is high; src_stall is raised in that cycle. Nothing is
//   dropped or repeated, and the held output does not change.
// Reset: arst_n clears all valid bits; payload registers are not reset.
//   The block accepts words right after reset is released.
module fixed_point_alu
	import fxalu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_stall,
	input  logic [3:0] func,
	input  logic signed [WORD_BITS-1:0] operand_a,
	input  logic signed [WORD_BITS-1:0] operand_b,
	output logic dst_valid,
	input  logic dst_stall,
	output logic signed [WORD_BITS-1:0] result,
	output logic less_than,
	output logic equal_to,
	output logic greater_than,
	output logic divide_by_zero
);

	localparam int W = WORD_BITS;
	localparam int NQ = WORD_BITS + FRAC_BITS; // quotient bits to resolve
	localparam int DV = WORD_BITS + FRAC_BITS; // dividend width

	logic en;

	// pipeline storage: stage 1 is capture, stages 2..NQ+1 follow divider steps
	logic vld_s [1:NQ+2];
	meta_t meta_s [1:NQ+1];
	logic [W-1:0] rem_s [1:NQ+1];
	logic [DV-1:0] dvd_s [1:NQ+1];
	logic [W-1:0] quo_s [1:NQ+1];
	logic [W-1:0] dsr_s [1:NQ+1];
	logic [W-1:0] ma_s1, mb_s1;

	// global advance: freeze everything while the output word is held
	assign en = !(vld_s[NQ+2] && dst_stall);
	assign src_stall = !en;

	// ---------------- capture stage ----------------
	logic lt_c, eq_c;
	logic [W-1:0] mag_a, mag_b, simple_c;

	assign lt_c = operand_a < operand_b;
	assign eq_c = operand_a == operand_b;
	assign mag_a = operand_a[W-1] ? W'(-operand_a) : W'(operand_a);
	assign mag_b = operand_b[W-1] ? W'(-operand_b) : W'(operand_b);

	always_comb begin
		case (func)
			FN_ADD: simple_c = W'(operand_a + operand_b);
			FN_SUB: simple_c = W'(operand_a - operand_b);
			FN_INC: simple_c = W'(operand_a + 1);
			FN_DEC: simple_c = W'(operand_a - 1);
			FN_MIN: simple_c = lt_c ? operand_a : operand_b;
			FN_MAX: simple_c = lt_c ? operand_b : operand_a;
			FN_FROM_INT: simple_c = W'(operand_a <<< FRAC_BITS);
			FN_TO_INT: simple_c = W'(operand_a >>> FRAC_BITS);
			default: simple_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[1].func <= func;
			meta_s[1].simple <= simple_c;
			meta_s[1].lt <= lt_c;
			meta_s[1].eq <= eq_c;
			meta_s[1].neg <= operand_a[W-1] ^ operand_b[W-1];
			meta_s[1].dz <= (func == FN_DIV) && (operand_b == '0);
			meta_s[1].prod <= '0;
			ma_s1 <= mag_a;
			mb_s1 <= mag_b;
			rem_s[1] <= '0;
			dvd_s[1] <= {mag_a, {FRAC_BITS{1'b0}}};
			quo_s[1] <= '0;
			dsr_s[1] <= mag_b;
		end
	end

	// ---------------- divider stages ----------------
	genvar k;
	generate
		for (k = 1; k <= NQ; k++) begin : g_stage
			logic [W:0] trial;
			logic take;
			meta_t meta_n;

			assign trial = {rem_s[k], dvd_s[k][DV-1]};
			assign take = trial >= {1'b0, dsr_s[k]};

			always_comb begin
				meta_n = meta_s[k];
				if (k == 1) begin
					meta_n.prod = (2*W)'(ma_s1) * (2*W)'(mb_s1);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (en) begin
					vld_s[k+1] <= vld_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					meta_s[k+1] <= meta_n;
					rem_s[k+1] <= take ? W'(trial - {1'b0, dsr_s[k]}) : trial[W-1:0];
					dvd_s[k+1] <= {dvd_s[k][DV-2:0], 1'b0};
					quo_s[k+1] <= {quo_s[k][W-2:0], take};
					dsr_s[k+1] <= dsr_s[k];
				end
			end
		end
	endgenerate

	// ---------------- output stage ----------------
	meta_t mf;
	logic [W-1:0] mag_r, res_c;

	assign mf = meta_s[NQ+1];

	always_comb begin
		mag_r = (mf.func == FN_MUL) ? mf.prod[FRAC_BITS +: W] : quo_s[NQ+1];
		if (mf.func == FN_MUL || mf.func == FN_DIV) begin
			res_c = mf.neg ? W'(-mag_r) : mag_r;
			if (mf.dz) begin
				res_c = '0;
			end
		end else begin
			res_c = mf.simple;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[NQ+2] <= 1'b0;
		end else if (en) begin
			vld_s[NQ+2] <= vld_s[NQ+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= res_c;
			less_than <= mf.lt;
			equal_to <= mf.eq;
			greater_than <= !mf.lt && !mf.eq;
			divide_by_zero <= mf.dz;
		end
	end

	assign dst_valid = vld_s[NQ+2];

`ifndef SYNTHESIS
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> $onehot({less_than, equal_to, greater_than}))
		else $error("comparison flags not one-hot");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && divide_by_zero) |-> (result == '0))
		else $error("divide by zero with nonzero result");
	a_dz_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && divide_by_zero && equal_to) |-> !less_than)
		else $error("divide by zero flags inconsistent");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[NQ+1]))
		else $error("pipeline moved while frozen");
`endif

endmodule
